FILE: rtl/y2r_pkg.sv
// Shared types, constants and the coefficient table of the YCbCr to RGB converter.
// No dependencies; every module of the block imports this package.
package y2r_pkg;

	// Field and datapath widths
	localparam int SAMPLE_W = 8;
	localparam int WORD_W   = 24;
	localparam int CH_W     = 8;
	localparam int COEF_W   = 18;
	localparam int OPND_W   = 9;
	localparam int TERM_W   = 28;
	localparam int SUM_W    = 28;
	localparam int FRAC_W   = 16;
	localparam int CFG_W    = 3;
	localparam int INDEX_W  = 2;

	// Register reset values
	localparam logic [2:0] MATRIX_RESET = 3'd6;

	// Full-precision path: luma scale, luma offset, chroma offset, rounding
	localparam logic [COEF_W-1:0] KY_BIG      = COEF_W'(76309);
	localparam logic [OPND_W-1:0] LUMA_OFFSET = OPND_W'(16);
	localparam logic [OPND_W-1:0] CHROMA_MID  = OPND_W'(128);
	localparam logic [SUM_W-1:0]  ROUND_BIG   = SUM_W'(32768);

	// Reduced path: decimal coefficients over 1000
	localparam logic [COEF_W-1:0] KY_SMALL  = COEF_W'(1000);
	localparam logic [COEF_W-1:0] KR_SMALL  = COEF_W'(1371);
	localparam logic [COEF_W-1:0] KGV_SMALL = COEF_W'(698);
	localparam logic [COEF_W-1:0] KGU_SMALL = COEF_W'(336);
	localparam logic [COEF_W-1:0] KB_SMALL  = COEF_W'(1732);

	// Division by 1000 as multiplication by ceil(2^28 / 1000); exact below 256000
	localparam int               DIV_N_W    = 18;
	localparam int               RECIP_W    = 19;
	localparam int               DIV_SHIFT  = 28;
	localparam int               RPROD_W    = DIV_N_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(268436);
	localparam logic [SUM_W-1:0] DIV_LIMIT  = SUM_W'(256000);

	typedef enum logic [1:0] {
		DEPTH_32 = 2'd0,
		DEPTH_24 = 2'd1,
		DEPTH_16 = 2'd2,
		DEPTH_15 = 2'd3
	} depth_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_MATRIX = 2'd0,
		REG_DEPTH  = 2'd1,
		REG_SWAP   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [2:0] matrix;
		depth_t     depth;
		logic       swap;
	} cfg_t;

	typedef struct packed {
		logic [COEF_W-1:0] r;
		logic [COEF_W-1:0] b;
		logic [COEF_W-1:0] gu;
		logic [COEF_W-1:0] gv;
	} coef_row_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] y;
		logic signed [TERM_W-1:0] r;
		logic signed [TERM_W-1:0] b;
		logic signed [TERM_W-1:0] gu;
		logic signed [TERM_W-1:0] gv;
	} terms_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] r;
		logic signed [SUM_W-1:0] g;
		logic signed [SUM_W-1:0] b;
	} sums_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} bytes_t;

	// True for the two modes that use the selectable 16.16 matrix
	function automatic logic full_mode(input depth_t d);
		return (d == DEPTH_32) || (d == DEPTH_24);
	endfunction

	// Coefficient rows by colour standard
	function automatic coef_row_t coef_row(input logic [2:0] sel);
		coef_row_t c;
		unique case (sel)
			3'd0:    c = '{COEF_W'(117504), COEF_W'(138453), COEF_W'(13954), COEF_W'(34903)};
			3'd1:    c = '{COEF_W'(117504), COEF_W'(138453), COEF_W'(13954), COEF_W'(34903)};
			3'd2:    c = '{COEF_W'(104597), COEF_W'(132201), COEF_W'(25675), COEF_W'(53279)};
			3'd3:    c = '{COEF_W'(104597), COEF_W'(132201), COEF_W'(25675), COEF_W'(53279)};
			3'd4:    c = '{COEF_W'(104448), COEF_W'(132798), COEF_W'(24759), COEF_W'(53109)};
			3'd5:    c = '{COEF_W'(104597), COEF_W'(132201), COEF_W'(25675), COEF_W'(53279)};
			3'd6:    c = '{COEF_W'(104597), COEF_W'(132201), COEF_W'(25675), COEF_W'(53279)};
			default: c = '{COEF_W'(117579), COEF_W'(136230), COEF_W'(16907), COEF_W'(35559)};
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/ycbcr_to_rgb_pixel_converter.sv
// Top level of the YCbCr to RGB converter: configuration registers and four pipeline stages.
// Depends on y2r_pkg, y2r_product, y2r_accum, y2r_range and y2r_pack.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+------------------------
//   pixel in | luma, chroma_blue, chroma_red             | pixel_valid/pixel_ready
//   word out | pixel_word                                | word_valid/word_ready
//   config   | cfg_index, cfg_data                       | cfg_we (no wait)
//
// One item enters per clock unless every stage is full behind a stalled output; each item
// passes in order through the product, sum, range and pack stage registers. Each stage
// takes a new item whenever it is empty or its item moves on, so bubbles close up and a
// stalled output holds without loss. Reset clears the stage valid bits and loads the
// registers with matrix 6, 32 bit depth and red-high order.
module ycbcr_to_rgb_pixel_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [y2r_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [y2r_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [y2r_pkg::SAMPLE_W-1:0]  luma,
	input  logic [y2r_pkg::SAMPLE_W-1:0]  chroma_blue,
	input  logic [y2r_pkg::SAMPLE_W-1:0]  chroma_red,
	output logic                          word_valid,
	input  logic                          word_ready,
	output logic [y2r_pkg::WORD_W-1:0]    pixel_word
);
	import y2r_pkg::*;

	cfg_t   cfg_q;
	logic   valid_s1, valid_s2, valid_s3, valid_s4;
	logic   ready_2, ready_3, ready_4;
	terms_t terms_s1;
	sums_t  sums_s2;
	bytes_t bytes_s3;

	// Write configuration registers; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.matrix <= MATRIX_RESET;
			cfg_q.depth  <= DEPTH_32;
			cfg_q.swap   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MATRIX: cfg_q.matrix <= cfg_data;
				REG_DEPTH:  cfg_q.depth  <= depth_t'(cfg_data[1:0]);
				REG_SWAP:   cfg_q.swap   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	y2r_product u_product (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.valid_in   (pixel_valid),
		.ready      (pixel_ready),
		.luma       (luma),
		.chroma_blue(chroma_blue),
		.chroma_red (chroma_red),
		.valid_s1   (valid_s1),
		.terms_s1   (terms_s1),
		.ready_down (ready_2)
	);

	y2r_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_in  (valid_s1),
		.ready     (ready_2),
		.terms     (terms_s1),
		.valid_s2  (valid_s2),
		.sums_s2   (sums_s2),
		.ready_down(ready_3)
	);

	y2r_range u_range (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_in  (valid_s2),
		.ready     (ready_3),
		.sums      (sums_s2),
		.valid_s3  (valid_s3),
		.bytes_s3  (bytes_s3),
		.ready_down(ready_4)
	);

	y2r_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_in  (valid_s3),
		.ready     (ready_4),
		.bytes     (bytes_s3),
		.valid_s4  (valid_s4),
		.word_s4   (pixel_word),
		.ready_down(word_ready)
	);

	assign word_valid = valid_s4;

`ifndef SYNTHESIS
	// Input is refused only when every stage holds an item
	assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input refused with a free pipeline stage");

	// An empty second stage always takes the first stage's item
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("item lost between stage 1 and stage 2");

	// Reduced depths leave the upper byte clear
	assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && !full_mode(cfg_q.depth)) |-> (pixel_word[23:16] == 8'h00))
		else $error("upper byte set in a 16 or 15 bit mode");

	// 555 packing leaves bit 15 clear
	assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && (cfg_q.depth == DEPTH_15)) |-> !pixel_word[15])
		else $error("bit 15 set in 15 bit mode");
`endif

endmodule

FILE: rtl/y2r_product.sv
// Stage 1 of the converter: picks coefficients and operands, forms the five products.
// Depends on y2r_pkg.
module y2r_product (
	input  logic                           clk,
	input  logic                           arst_n,
	input  y2r_pkg::cfg_t                  cfg,
	input  logic                           valid_in,
	output logic                           ready,
	input  logic [y2r_pkg::SAMPLE_W-1:0]   luma,
	input  logic [y2r_pkg::SAMPLE_W-1:0]   chroma_blue,
	input  logic [y2r_pkg::SAMPLE_W-1:0]   chroma_red,
	output logic                           valid_s1,
	output y2r_pkg::terms_t                terms_s1,
	input  logic                           ready_down
);
	import y2r_pkg::*;

	logic                     full;
	coef_row_t                row;
	logic [SAMPLE_W-1:0]      y_trunc, cb_trunc, cr_trunc;
	logic signed [OPND_W-1:0] ys, us, vs;
	logic [COEF_W-1:0]        ky, kr, kb, kgu, kgv;
	terms_t                   terms;

	// Widen both operands first so the product keeps the full term width
	function automatic logic signed [TERM_W-1:0] mul_term(
		input logic [COEF_W-1:0] k,
		input logic signed [OPND_W-1:0] x
	);
		logic signed [TERM_W-1:0] kw;
		logic signed [TERM_W-1:0] xw;
		kw = $signed(TERM_W'(k));
		xw = TERM_W'(x);
		return kw * xw;
	endfunction

	// Select operands: full samples less offsets, or samples cut to 6 bits
	always_comb begin
		full     = full_mode(cfg.depth);
		row      = coef_row(cfg.matrix);
		y_trunc  = {luma[SAMPLE_W-1:2], 2'b00};
		cb_trunc = {chroma_blue[SAMPLE_W-1:2], 2'b00};
		cr_trunc = {chroma_red[SAMPLE_W-1:2], 2'b00};
		if (full) begin
			ys  = $signed({1'b0, luma} - LUMA_OFFSET);
			us  = $signed({1'b0, chroma_blue} - CHROMA_MID);
			vs  = $signed({1'b0, chroma_red} - CHROMA_MID);
			ky  = KY_BIG;
			kr  = row.r;
			kb  = row.b;
			kgu = row.gu;
			kgv = row.gv;
		end else begin
			ys  = $signed({1'b0, y_trunc});
			us  = $signed({1'b0, cb_trunc} - CHROMA_MID);
			vs  = $signed({1'b0, cr_trunc} - CHROMA_MID);
			ky  = KY_SMALL;
			kr  = KR_SMALL;
			kb  = KB_SMALL;
			kgu = KGU_SMALL;
			kgv = KGV_SMALL;
		end
		terms.y  = mul_term(ky, ys);
		terms.r  = mul_term(kr, vs);
		terms.b  = mul_term(kb, us);
		terms.gu = mul_term(kgu, us);
		terms.gv = mul_term(kgv, vs);
	end

	assign ready = !valid_s1 || ready_down;

	// Advance the stage when empty or when the next stage takes its item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_in) begin
			terms_s1 <= terms;
		end
	end

endmodule

FILE: rtl/y2r_accum.sv
// Stage 2 of the converter: adds the products into one signed sum per channel.
// Depends on y2r_pkg.
module y2r_accum (
	input  logic             clk,
	input  logic             arst_n,
	input  y2r_pkg::cfg_t    cfg,
	input  logic             valid_in,
	output logic             ready,
	input  y2r_pkg::terms_t  terms,
	output logic             valid_s2,
	output y2r_pkg::sums_t   sums_s2,
	input  logic             ready_down
);
	import y2r_pkg::*;

	logic [SUM_W-1:0] rnd;
	sums_t            sums;

	// Add rounding only on the 16.16 path
	always_comb begin
		rnd    = full_mode(cfg.depth) ? ROUND_BIG : '0;
		sums.r = terms.y + terms.r + $signed(rnd);
		sums.g = terms.y - terms.gu - terms.gv + $signed(rnd);
		sums.b = terms.y + terms.b + $signed(rnd);
	end

	assign ready = !valid_s2 || ready_down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_in) begin
			sums_s2 <= sums;
		end
	end

endmodule

FILE: rtl/y2r_range.sv
// Stage 3 of the converter: scales each sum down and clamps it to one byte.
// Depends on y2r_pkg.
module y2r_range (
	input  logic             clk,
	input  logic             arst_n,
	input  y2r_pkg::cfg_t    cfg,
	input  logic             valid_in,
	output logic             ready,
	input  y2r_pkg::sums_t   sums,
	output logic             valid_s3,
	output y2r_pkg::bytes_t  bytes_s3,
	input  logic             ready_down
);
	import y2r_pkg::*;

	bytes_t bytes;
	logic   full;

	// Negative clamps to zero, overflow to 255; 16.16 takes the integer byte, the other path divides by 1000
	function automatic logic [CH_W-1:0] to_byte(
		input logic signed [SUM_W-1:0] s,
		input logic                    big
	);
		logic [RPROD_W-1:0] prod;
		logic [CH_W-1:0]    res;
		prod = {{RECIP_W{1'b0}}, s[DIV_N_W-1:0]} * {{DIV_N_W{1'b0}}, RECIP};
		if (s[SUM_W-1]) begin
			res = '0;
		end else if (big) begin
			res = (s[SUM_W-2:FRAC_W+CH_W] != '0) ? {CH_W{1'b1}} : s[FRAC_W+CH_W-1:FRAC_W];
		end else begin
			res = (s >= DIV_LIMIT) ? {CH_W{1'b1}} : prod[DIV_SHIFT+CH_W-1:DIV_SHIFT];
		end
		return res;
	endfunction

	always_comb begin
		full    = full_mode(cfg.depth);
		bytes.r = to_byte(sums.r, full);
		bytes.g = to_byte(sums.g, full);
		bytes.b = to_byte(sums.b, full);
	end

	assign ready = !valid_s3 || ready_down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready) begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_in) begin
			bytes_s3 <= bytes;
		end
	end

endmodule

FILE: rtl/y2r_pack.sv
// Stage 4 of the converter: packs the channel bytes into the output word register.
// Depends on y2r_pkg.
module y2r_pack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  y2r_pkg::cfg_t                 cfg,
	input  logic                          valid_in,
	output logic                          ready,
	input  y2r_pkg::bytes_t               bytes,
	output logic                          valid_s4,
	output logic [y2r_pkg::WORD_W-1:0]    word_s4,
	input  logic                          ready_down
);
	import y2r_pkg::*;

	logic [CH_W-1:0]   hi, lo;
	logic [WORD_W-1:0] word;

	// Order channels, then pack as 888, 565 or 555
	always_comb begin
		hi = cfg.swap ? bytes.b : bytes.r;
		lo = cfg.swap ? bytes.r : bytes.b;
		unique case (cfg.depth)
			DEPTH_32, DEPTH_24: word = {hi, bytes.g, lo};
			DEPTH_16:           word = {8'h00, hi[7:3], bytes.g[7:2], lo[7:3]};
			default:            word = {9'h000, hi[7:3], bytes.g[7:3], lo[7:3]};
		endcase
	end

	assign ready = !valid_s4 || ready_down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready) begin
			valid_s4 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_in) begin
			word_s4 <= word;
		end
	end

endmodule

FILE: bench/ycbcr_to_rgb_pixel_converter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the YCbCr to RGB pixel converter: directed and random pixels
// under bursty input, output stalls and a long output hold-off. Depends on y2r_pkg.
module ycbcr_to_rgb_pixel_converter_tb;
	import y2r_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_PIXELS = 89;
	localparam logic [INDEX_W-1:0] REG_NONE = 2'd3;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_MOSTLY,
		RX_EVERY_THIRD
	} rx_pattern_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                pixel_valid = 1'b0;
	logic                pixel_ready;
	logic [SAMPLE_W-1:0] luma = '0;
	logic [SAMPLE_W-1:0] chroma_blue = '0;
	logic [SAMPLE_W-1:0] chroma_red = '0;
	logic                word_valid;
	logic                word_ready = 1'b0;
	logic [WORD_W-1:0]   pixel_word;

	// Register copies as the block should hold them
	logic [2:0]          cur_matrix = MATRIX_RESET;
	depth_t              cur_depth = DEPTH_32;
	logic                cur_swap = 1'b0;

	logic [WORD_W-1:0]   expected_words[$];
	int                  fault_count = 0;
	int                  burst_left = 0;
	bit                  gaps_on = 1'b1;
	int                  hold_left = 0;
	rx_pattern_t         rx_pattern = RX_ALWAYS;
	int                  pattern_left = 0;
	int                  rx_tick = 0;

	ycbcr_to_rgb_pixel_converter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.luma        (luma),
		.chroma_blue (chroma_blue),
		.chroma_red  (chroma_red),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.pixel_word  (pixel_word)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drop negative sums, take the integer part of a 16.16 value, saturate at 255
	function automatic logic [7:0] clamp_fixed(input longint v);
		if (v < 0)
			return 8'd0;
		v = v >>> 16;
		return (v > 255) ? 8'd255 : 8'(v);
	endfunction

	function automatic logic [7:0] clamp_channel(input longint v);
		if (v < 0)
			return 8'd0;
		return (v > 255) ? 8'd255 : 8'(v);
	endfunction

	// Packed RGB word for one pixel under the current register copies
	function automatic logic [WORD_W-1:0] predict_word(input logic [7:0] y8, cb8, cr8);
		longint y, u, v, yy, kr, kb, kgu, kgv, yq, uq, vq;
		logic [7:0] r, g, b, hi, lo;
		bit is16;
		y = y8;
		if (cur_depth == DEPTH_32 || cur_depth == DEPTH_24) begin
			case (cur_matrix)
				3'd0, 3'd1: begin
					kr = 117504; kb = 138453; kgu = 13954; kgv = 34903;
				end
				3'd4: begin
					kr = 104448; kb = 132798; kgu = 24759; kgv = 53109;
				end
				3'd7: begin
					kr = 117579; kb = 136230; kgu = 16907; kgv = 35559;
				end
				default: begin
					kr = 104597; kb = 132201; kgu = 25675; kgv = 53279;
				end
			endcase
			u = longint'(cb8) - 128;
			v = longint'(cr8) - 128;
			yy = 76309 * (y - 16);
			r = clamp_fixed(yy + kr * v + 32768);
			g = clamp_fixed(yy - (kgu * u + kgv * v - 32768));
			b = clamp_fixed(yy + kb * u + 32768);
			hi = cur_swap ? b : r;
			lo = cur_swap ? r : b;
			return {hi, g, lo};
		end
		// Reduced modes: 6 bit samples, fixed decimal coefficients, truncating division
		is16 = (cur_depth == DEPTH_16);
		yq = (y >> 2) << 2;
		uq = ((longint'(cb8) >> 2) << 2) - 128;
		vq = ((longint'(cr8) >> 2) << 2) - 128;
		r = clamp_channel((yq * 1000 + 1371 * vq) / 1000) >> 3;
		g = clamp_channel((yq * 1000 - 698 * vq - 336 * uq) / 1000) >> (is16 ? 2 : 3);
		b = clamp_channel((yq * 1000 + 1732 * uq) / 1000) >> 3;
		hi = cur_swap ? b : r;
		lo = cur_swap ? r : b;
		return (WORD_W'(hi) << (is16 ? 11 : 10)) | (WORD_W'(g) << 5) | WORD_W'(lo);
	endfunction

	function automatic void note_fault(input string msg);
		if (fault_count < MAX_REPORTS)
			$display("%0t: %s", $time, msg);
		fault_count++;
	endfunction

	// Extremes and the neutral points now and then, otherwise any value
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 11))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd16;
			3: return 8'd128;
			default: return 8'($urandom);
		endcase
	endfunction

	// Write one register while the block is idle and track it
	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MATRIX: cur_matrix = data;
			REG_DEPTH:  cur_depth = depth_t'(data[1:0]);
			REG_SWAP:   cur_swap = data[0];
			default: ;
		endcase
	endtask

	// Offer one pixel, hold it until taken, then queue its word
	task automatic send_pixel(input logic [7:0] y, cb, cr);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		pixel_valid <= 1'b1;
		luma <= y;
		chroma_blue <= cb;
		chroma_red <= cr;
		do @(posedge clk); while (!pixel_ready);
		burst_left--;
		expected_words.push_back(predict_word(y, cb, cr));
	endtask

	// Drop valid in the step of the last acceptance, then wait for every word
	task automatic finish_stream();
		pixel_valid <= 1'b0;
		burst_left = 0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_values();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd16, 8'd128, 8'd128);
		finish_stream();
	endtask

	task automatic test_matrix_rows();
		for (int m = 0; m < 8; m++) begin
			write_reg(REG_MATRIX, CFG_W'(m));
			send_pixel(8'd128, 8'd40, 8'd220);
			finish_stream();
		end
	endtask

	// Same pixel through every depth and both orders; 32 and 24 bit must agree
	task automatic test_depth_and_order();
		for (int d = 0; d < 4; d++) begin
			for (int s = 0; s < 2; s++) begin
				write_reg(REG_DEPTH, CFG_W'(d));
				write_reg(REG_SWAP, CFG_W'(s));
				send_pixel(8'd200, 8'd30, 8'd230);
				finish_stream();
			end
		end
	endtask

	// Upper bits of narrow registers, unknown index, matrix in the reduced modes
	task automatic test_register_width();
		write_reg(REG_DEPTH, 3'b110);
		write_reg(REG_SWAP, 3'b010);
		write_reg(REG_NONE, 3'b111);
		write_reg(REG_MATRIX, 3'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
		finish_stream();
		write_reg(REG_MATRIX, 3'd7);
		send_pixel(8'd255, 8'd0, 8'd255);
		finish_stream();
	endtask

	// Hold the output off for a long stretch while pixels keep coming
	task automatic test_output_backpressure();
		write_reg(REG_DEPTH, CFG_W'(DEPTH_32));
		write_reg(REG_MATRIX, 3'd4);
		gaps_on = 1'b0;
		hold_left = 150;
		for (int i = 0; i < 40; i++)
			send_pixel(pick_sample(), pick_sample(), pick_sample());
		finish_stream();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_streams();
		logic [2:0] m;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			m = (p == 0) ? 3'd0 : (p == RANDOM_PHASES - 1) ? 3'd7 : 3'($urandom_range(0, 7));
			write_reg(REG_MATRIX, m);
			write_reg(REG_DEPTH, {1'($urandom_range(0, 1)), 2'(p % 4)});
			write_reg(REG_SWAP, {2'($urandom_range(0, 3)), 1'((p / 4) % 2)});
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_NONE, 3'($urandom_range(0, 7)));
			for (int i = 0; i < PHASE_PIXELS; i++)
				send_pixel(pick_sample(), pick_sample(), pick_sample());
			finish_stream();
		end
	endtask

	// Output side: long hold when asked, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			word_ready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(32, 400);
			end
			pattern_left--;
			rx_tick++;
			case (rx_pattern)
				RX_ALWAYS:  word_ready <= 1'b1;
				RX_COIN:    word_ready <= 1'($urandom_range(0, 1));
				RX_MOSTLY:  word_ready <= ($urandom_range(0, 9) != 0);
				default:    word_ready <= (rx_tick % 3 == 0);
			endcase
		end
	end

	// Compare every accepted word with the oldest prediction
	always @(posedge clk) begin
		logic [WORD_W-1:0] want;
		if (arst_n && word_valid && word_ready) begin
			if (expected_words.size() == 0) begin
				note_fault($sformatf("unexpected word %06h", pixel_word));
			end else begin
				want = expected_words.pop_front();
				if (pixel_word !== want)
					note_fault($sformatf("pixel_word expected %06h got %06h", want, pixel_word));
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_matrix_rows();
		test_depth_and_order();
		test_register_width();
		test_output_backpressure();
		test_random_streams();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			note_fault($sformatf("%0d words never arrived", expected_words.size()));
		if (fault_count == 0)
			$display("ycbcr_to_rgb_pixel_converter: match");
		else
			$display("ycbcr_to_rgb_pixel_converter: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("ycbcr_to_rgb_pixel_converter: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/y2r_pkg.sv
rtl/y2r_product.sv
rtl/y2r_accum.sv
rtl/y2r_range.sv
rtl/y2r_pack.sv
rtl/ycbcr_to_rgb_pixel_converter.sv
bench/ycbcr_to_rgb_pixel_converter_tb.sv
